// ===== rtl/core/hierarchical_bitmap_set_clear_find_top_defines.svh =====
// ----------------------------------------------------------------------------
// Hierarchical bitmap assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef HIERARCHICAL_BITMAP_SET_CLEAR_FIND_TOP_DEFINES_SVH
`define HIERARCHICAL_BITMAP_SET_CLEAR_FIND_TOP_DEFINES_SVH

`ifndef SYNTH
// check on every clock edge outside reset
`define HBM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check on every clock edge, also during reset
`define HBM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HBM_ASSERT(lbl, prop, msg)
`define HBM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/hbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Hierarchical bitmap package
// Widths, field layout and beat types shared by the bitmap block.
// ----------------------------------------------------------------------------
`default_nettype none

package hbm_pkg;

	localparam int WORD_BITS  = 32;
	localparam int POS_W      = 5;
	localparam int IDX_W      = 15;
	localparam int LEAF_COUNT = 1024;
	localparam int LEAF_AW    = 10;
	localparam int MID_COUNT  = 32;
	localparam int MID_LSB    = 10;   // bit_index[14:10] picks the middle word
	localparam int LEAF_LSB   = 5;    // bit_index[14:5] picks the leaf word
	localparam int CFG_W      = 16;
	localparam logic [CFG_W-1:0] NUM_BITS_RESET = 16'd32768;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [POS_W-1:0]     pos_t;
	typedef logic [IDX_W-1:0]     idx_t;

	typedef enum logic [1:0] {
		FUNC_SET   = 2'd0,
		FUNC_CLEAR = 2'd1,
		FUNC_TEST  = 2'd2,
		FUNC_FIND  = 2'd3
	} func_t;

	typedef struct packed {
		func_t func;
		idx_t  bit_index;
	} req_t;

	typedef struct packed {
		logic bit_value;
		logic found;
		idx_t found_index;
		logic index_error;
	} rsp_t;

	// word unit control and result
	typedef struct packed {
		logic clr;
		pos_t pos;
	} wu_ctl_t;

	typedef struct packed {
		word_t new_word;
		logic  climb;
		logic  nonzero;
		pos_t  lowest;
	} wu_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/hbm_chan_if.sv =====
// ----------------------------------------------------------------------------
// Hierarchical bitmap channel
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface hbm_chan_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/hierarchical_bitmap_set_clear_find_top.sv =====
// ----------------------------------------------------------------------------
// Hierarchical bitmap set / clear / find top level
// Three-level bitmap of 32-bit words (leaf RAM, middle words, top word)
// with set, clear, test and find-lowest-set operations.
//
// Usage:
//   req: request beats {func, bit_index}; ready is high only when idle.
//   rsp: one response beat per request {bit_value, found, found_index,
//        index_error}, held in an output register until taken.
//   cfg_we/cfg_wdata write num_bits; write it only while idle.
//   An index error goes straight to the response. Set and clear climb one
//     more level for each level that changes between empty and nonempty;
//     find stops after the top word on an empty map. The next request beat
//     is taken only once the previous response has moved to the output
//     register. Tree steps share the one word unit and the single leaf
//     RAM port, one tree level per cycle.
//   A finished response moves to the output register; if that register is
//   still full because rsp stalls, the sequencer waits and req.ready stays low.
//   Reset clears the middle and top words and sets num_bits to 32768; no
//   clearing pass is needed, since a leaf word whose middle bit is clear
//   reads as zero whatever the RAM holds.
// ----------------------------------------------------------------------------
`default_nettype none

module hierarchical_bitmap_set_clear_find_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [hbm_pkg::CFG_W-1:0] cfg_wdata,
	hbm_chan_if.sink                  req,
	hbm_chan_if.source                rsp
);
	import hbm_pkg::*;

	`include "hierarchical_bitmap_set_clear_find_top_defines.svh"

	typedef enum logic [3:0] {
		S_IDLE,
		S_TEST,
		S_LEAF_WR,
		S_MID,
		S_TOP,
		S_FIND_TOP,
		S_FIND_MID,
		S_FIND_LEAF,
		S_EMIT
	} state_t;

	state_t            state_q;
	req_t              op_q;
	rsp_t              res_q;
	rsp_t              out_q;
	logic              out_valid_q;
	logic [CFG_W-1:0]  num_bits_q;
	word_t             mid_q [MID_COUNT];
	word_t             top_q;
	pos_t              hi_q;
	pos_t              lo_q;

	word_t             leaf_mem [LEAF_COUNT];
	word_t             rdata_q;
	logic              mem_re;
	logic              mem_we;
	logic [LEAF_AW-1:0] mem_raddr;

	logic              accept;
	logic              emit_go;
	logic              idx_err;
	pos_t              top_pos;
	pos_t              mid_pos;
	pos_t              leaf_pos;
	word_t             leaf_old;
	word_t             wu_old;
	wu_ctl_t           wu_ctl;
	wu_res_t           wu_res;
	word_t             mid_nz;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// finished response moves into a free or draining output register
	assign emit_go   = (state_q == S_EMIT) && (!out_valid_q || rsp.ready);

	// range check against num_bits (15-bit index never reaches 32768)
	assign idx_err = ({1'b0, req.data.bit_index} >= num_bits_q);

	// index slices of the held request
	assign top_pos  = op_q.bit_index[IDX_W-1:MID_LSB];
	assign mid_pos  = op_q.bit_index[MID_LSB-1:LEAF_LSB];
	assign leaf_pos = op_q.bit_index[LEAF_LSB-1:0];

	// a leaf word is valid only while its middle bit marks it nonempty
	assign leaf_old = mid_q[top_pos][mid_pos] ? rdata_q : '0;

	// shared word unit operand select
	always_comb begin
		wu_ctl.clr = (op_q.func == FUNC_CLEAR);
		wu_ctl.pos = leaf_pos;
		wu_old     = '0;
		case (state_q)
			S_LEAF_WR: begin
				wu_old = leaf_old;
			end
			S_MID: begin
				wu_old     = mid_q[top_pos];
				wu_ctl.pos = mid_pos;
			end
			S_TOP: begin
				wu_old     = top_q;
				wu_ctl.pos = top_pos;
			end
			S_FIND_TOP: begin
				wu_old = top_q;
			end
			S_FIND_MID: begin
				wu_old = mid_q[hi_q];
			end
			S_FIND_LEAF: begin
				wu_old = rdata_q;
			end
			default: begin
				wu_old = '0;
			end
		endcase
	end

	hbm_word_unit u_word_unit (
		.old_word (wu_old),
		.ctl      (wu_ctl),
		.res      (wu_res)
	);

	// leaf RAM port control
	always_comb begin
		mem_we    = (state_q == S_LEAF_WR);
		mem_re    = 1'b0;
		mem_raddr = req.data.bit_index[IDX_W-1:LEAF_LSB];
		if (accept) begin
			mem_re = 1'b1;
		end else if (state_q == S_FIND_MID) begin
			mem_re    = 1'b1;
			mem_raddr = {hi_q, wu_res.lowest};
		end
	end

	// leaf RAM, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			leaf_mem[op_q.bit_index[IDX_W-1:LEAF_LSB]] <= wu_res.new_word;
		end
		if (mem_re) begin
			rdata_q <= leaf_mem[mem_raddr];
		end
	end

	// sequencer, upper levels and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			num_bits_q  <= NUM_BITS_RESET;
			top_q       <= '0;
			hi_q        <= '0;
			lo_q        <= '0;
			for (int i = 0; i < MID_COUNT; i++) begin
				mid_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				num_bits_q <= cfg_wdata;
			end
			// output valid: set on a new response, cleared when taken
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q  <= req.data;
						res_q <= '{bit_value: 1'b0, found: 1'b0, found_index: '0,
							index_error: (req.data.func != FUNC_FIND) && idx_err};
						if (req.data.func == FUNC_FIND) begin
							state_q <= S_FIND_TOP;
						end else if (idx_err) begin
							state_q <= S_EMIT;
						end else if (req.data.func == FUNC_TEST) begin
							state_q <= S_TEST;
						end else begin
							state_q <= S_LEAF_WR;
						end
					end
				end
				S_TEST: begin
					res_q.bit_value <= leaf_old[leaf_pos];
					state_q         <= S_EMIT;
				end
				S_LEAF_WR: begin
					state_q <= wu_res.climb ? S_MID : S_EMIT;
				end
				S_MID: begin
					mid_q[top_pos] <= wu_res.new_word;
					state_q        <= wu_res.climb ? S_TOP : S_EMIT;
				end
				S_TOP: begin
					top_q   <= wu_res.new_word;
					state_q <= S_EMIT;
				end
				S_FIND_TOP: begin
					hi_q    <= wu_res.lowest;
					state_q <= wu_res.nonzero ? S_FIND_MID : S_EMIT;
				end
				S_FIND_MID: begin
					lo_q    <= wu_res.lowest;
					state_q <= S_FIND_LEAF;
				end
				S_FIND_LEAF: begin
					res_q   <= '{bit_value: 1'b0, found: 1'b1,
						found_index: {hi_q, lo_q, wu_res.lowest}, index_error: 1'b0};
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// nonempty flags of the middle words, for checking the top word
	always_comb begin
		for (int i = 0; i < MID_COUNT; i++) begin
			mid_nz[i] = (mid_q[i] != '0);
		end
	end

	`HBM_ASSERT(a_top_mirrors_mid, (state_q == S_IDLE) |-> (top_q == mid_nz),
		"top word out of step with middle words")
	`HBM_ASSERT(a_find_leaf_nonempty, (state_q == S_FIND_LEAF) |-> (rdata_q != '0),
		"find reached an empty leaf word")
	`HBM_ASSERT(a_beat_starts_work, accept |=> (state_q != S_IDLE),
		"request beat taken but sequencer idle")
	`HBM_ASSERT(a_err_excl,
		(out_valid_q && out_q.index_error) |-> (!out_q.found && !out_q.bit_value),
		"error response carries data")

endmodule

`default_nettype wire

// ===== rtl/core/hbm_word_unit.sv =====
// ----------------------------------------------------------------------------
// Hierarchical bitmap word unit
// Shared per-word logic: set or clear one bit, detect the empty/nonempty
// transition, and find the lowest set bit.
// ----------------------------------------------------------------------------
`default_nettype none

module hbm_word_unit (
	input  hbm_pkg::word_t   old_word,
	input  hbm_pkg::wu_ctl_t ctl,
	output hbm_pkg::wu_res_t res
);
	import hbm_pkg::*;

	word_t mask;

	// bit update, transition detect and lowest set bit
	always_comb begin
		mask         = word_t'(1) << ctl.pos;
		res.new_word = ctl.clr ? (old_word & ~mask) : (old_word | mask);
		res.nonzero  = (old_word != '0);
		res.climb    = ctl.clr ? ((old_word != '0) && (res.new_word == '0))
		                       : ((old_word == '0) && (res.new_word != '0));
		// priority from the top down so bit 0 wins
		res.lowest = pos_t'(WORD_BITS - 1);
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (old_word[i]) begin
				res.lowest = pos_t'(i);
			end
		end
	end

endmodule

`default_nettype wire

// ===== sim/hierarchical_bitmap_set_clear_find_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hierarchical bitmap set / clear / find testbench
// Drives set, clear, test and find beats into the bitmap, keeps a shadow
// copy of the three word levels, and checks every response beat field by
// field against the shadow's answer, under several num_bits settings and
// sender / receiver idling patterns.
// ----------------------------------------------------------------------------

// Shadow of the bitmap store plus the queue of answers still owed by the block
class bitmap_shadow;

	hbm_pkg::word_t leaf_words[hbm_pkg::LEAF_COUNT];
	hbm_pkg::word_t mid_words[hbm_pkg::MID_COUNT];
	hbm_pkg::word_t top_word;
	logic [hbm_pkg::CFG_W-1:0] num_bits;
	hbm_pkg::rsp_t op_answer_q[$];
	int unsigned mismatch_count;

	function new();
		foreach (leaf_words[i]) leaf_words[i] = '0;
		foreach (mid_words[i]) mid_words[i] = '0;
		top_word = '0;
		num_bits = hbm_pkg::NUM_BITS_RESET;
		mismatch_count = 0;
	endfunction

	function int pending();
		return op_answer_q.size();
	endfunction

	// position of the lowest set bit (0 for an empty word)
	function hbm_pkg::pos_t lowest_pos(hbm_pkg::word_t w);
		hbm_pkg::pos_t p;
		p = '0;
		for (int i = hbm_pkg::WORD_BITS - 1; i >= 0; i--) begin
			if (w[i]) p = hbm_pkg::pos_t'(i);
		end
		return p;
	endfunction

	// apply one operation to the shadow store and return its answer
	function hbm_pkg::rsp_t apply_bitmap_op(hbm_pkg::req_t op);
		hbm_pkg::rsp_t ans;
		logic [16:0] lim;
		logic [hbm_pkg::LEAF_AW-1:0] lw;
		hbm_pkg::pos_t mw, tp, mp;
		hbm_pkg::word_t old_w, new_w;
		ans = '0;
		lim = (num_bits > 16'd32768) ? 17'd32768 : {1'b0, num_bits};
		lw = op.bit_index[14:5];
		mw = op.bit_index[14:10];
		if (op.func == hbm_pkg::FUNC_FIND) begin
			// descend top -> middle -> leaf along the lowest set bits
			if (top_word != '0) begin
				tp = lowest_pos(top_word);
				if (mid_words[tp] != '0) begin
					mp = lowest_pos(mid_words[tp]);
					if (leaf_words[{tp, mp}] != '0) begin
						ans.found = 1'b1;
						ans.found_index = {tp, mp, lowest_pos(leaf_words[{tp, mp}])};
					end
				end
			end
		end else if ({2'b00, op.bit_index} >= lim) begin
			ans.index_error = 1'b1;
		end else if (op.func == hbm_pkg::FUNC_TEST) begin
			ans.bit_value = leaf_words[lw][op.bit_index[4:0]];
		end else if (op.func == hbm_pkg::FUNC_SET) begin
			// a word going nonempty marks itself one level up
			old_w = leaf_words[lw];
			leaf_words[lw][op.bit_index[4:0]] = 1'b1;
			if (old_w == '0) begin
				old_w = mid_words[mw];
				mid_words[mw][op.bit_index[9:5]] = 1'b1;
				if (old_w == '0) top_word[mw] = 1'b1;
			end
		end else begin
			// a word going empty unmarks itself one level up
			old_w = leaf_words[lw];
			new_w = old_w;
			new_w[op.bit_index[4:0]] = 1'b0;
			leaf_words[lw] = new_w;
			if (old_w != '0 && new_w == '0) begin
				old_w = mid_words[mw];
				new_w = old_w;
				new_w[op.bit_index[9:5]] = 1'b0;
				mid_words[mw] = new_w;
				if (old_w != '0 && new_w == '0) top_word[mw] = 1'b0;
			end
		end
		return ans;
	endfunction

	function void note_request(hbm_pkg::req_t op);
		op_answer_q.push_back(apply_bitmap_op(op));
	endfunction

	function void check_answer(hbm_pkg::rsp_t got);
		hbm_pkg::rsp_t want;
		if (op_answer_q.size() == 0) begin
			$error("rsp beat with no request outstanding");
			mismatch_count++;
			return;
		end
		want = op_answer_q.pop_front();
		if (got.bit_value !== want.bit_value) begin
			$error("bit_value: expected %0d, actual %0d", want.bit_value, got.bit_value);
			mismatch_count++;
		end
		if (got.found !== want.found) begin
			$error("found: expected %0d, actual %0d", want.found, got.found);
			mismatch_count++;
		end
		if (got.found_index !== want.found_index) begin
			$error("found_index: expected %0d, actual %0d", want.found_index,
				got.found_index);
			mismatch_count++;
		end
		if (got.index_error !== want.index_error) begin
			$error("index_error: expected %0d, actual %0d", want.index_error,
				got.index_error);
			mismatch_count++;
		end
	endfunction

endclass

module hierarchical_bitmap_set_clear_find_top_test;

	localparam int CYCLE_LIMIT = 400000;

	typedef logic [hbm_pkg::LEAF_AW-1:0] leaf_addr_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [hbm_pkg::CFG_W-1:0] cfg_wdata;

	hbm_chan_if #(.payload_t(hbm_pkg::req_t)) req_ch ();
	hbm_chan_if #(.payload_t(hbm_pkg::rsp_t)) rsp_ch ();

	bitmap_shadow shadow = new();

	int send_idle_pct = 0;
	int stall_pct = 0;
	int unsigned cycle_count = 0;

	hierarchical_bitmap_set_clear_find_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("hierarchical_bitmap_set_clear_find_top_test NOT OK");
			$finish;
		end
	end

	// response side: check accepted beats, stall at random
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) shadow.check_answer(rsp_ch.data);
		rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// one request beat, with optional idle cycles carrying junk payload first
	task automatic send_req(input hbm_pkg::req_t op);
		hbm_pkg::req_t noise;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			do begin
				noise.func = hbm_pkg::func_t'($urandom_range(0, 3));
				noise.bit_index = hbm_pkg::idx_t'($urandom);
				req_ch.data <= noise;
				@(posedge clk);
			end while ($urandom_range(0, 99) < send_idle_pct);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= op;
		do @(posedge clk); while (!req_ch.ready);
		shadow.note_request(op);
	endtask

	task automatic run_op(input hbm_pkg::func_t f, input int unsigned idx);
		send_req('{func: f, bit_index: idx[14:0]});
	endtask

	// stop sending and wait for every owed response, then settle
	task automatic wait_idle(input int settle);
		req_ch.valid <= 1'b0;
		while (shadow.pending() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_num_bits(input logic [hbm_pkg::CFG_W-1:0] nb);
		cfg_we <= 1'b1;
		cfg_wdata <= nb;
		@(posedge clk);
		shadow.num_bits = nb;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// random beats clustered on a few hot words so that words fill and drain
	task automatic run_phase(input int send_pct, input int stall,
			input logic [hbm_pkg::CFG_W-1:0] nb, input int count);
		int unsigned lim, nwords, idx;
		leaf_addr_t hot_w[4];
		hbm_pkg::pos_t hot_p[4];
		hbm_pkg::func_t f;
		int r;
		wait_idle(4);
		write_num_bits(nb);
		send_idle_pct = send_pct;
		stall_pct = stall;
		lim = (nb > 16'd32768) ? 32768 : 32'(nb);
		nwords = (lim + 31) / 32;
		hot_w[0] = leaf_addr_t'($urandom_range(0, nwords - 1));
		hot_w[1] = ((32'(hot_w[0]) ^ 32'd1) < nwords) ? (hot_w[0] ^ leaf_addr_t'(1))
			: hot_w[0];
		hot_w[2] = leaf_addr_t'($urandom_range(0, nwords - 1));
		hot_w[3] = leaf_addr_t'(nwords - 1);
		hot_p[0] = 5'd0;
		hot_p[1] = hbm_pkg::pos_t'($urandom_range(0, 31));
		hot_p[2] = hbm_pkg::pos_t'($urandom_range(0, 31));
		hot_p[3] = 5'd31;
		for (int i = 0; i < count; i++) begin
			// hold off once per phase until the block has answered everything
			if (i == count / 2) wait_idle(1);
			r = $urandom_range(0, 99);
			if (r < 60) idx = 32'({hot_w[$urandom_range(0, 3)], hot_p[$urandom_range(0, 3)]});
			else if (r < 70) idx = lim - 1 + $urandom_range(0, 2);
			else idx = $urandom_range(0, 32767);
			r = $urandom_range(0, 99);
			if (r < 38) f = hbm_pkg::FUNC_SET;
			else if (r < 76) f = hbm_pkg::FUNC_CLEAR;
			else if (r < 88) f = hbm_pkg::FUNC_TEST;
			else f = hbm_pkg::FUNC_FIND;
			run_op(f, idx);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_num_bits(16'd32768);

		// empty map, extremes, redundant set and clear
		run_op(hbm_pkg::FUNC_FIND, 0);
		run_op(hbm_pkg::FUNC_TEST, 0);
		run_op(hbm_pkg::FUNC_SET, 0);
		run_op(hbm_pkg::FUNC_SET, 0);
		run_op(hbm_pkg::FUNC_SET, 32767);
		run_op(hbm_pkg::FUNC_TEST, 32767);
		run_op(hbm_pkg::FUNC_FIND, 0);
		run_op(hbm_pkg::FUNC_CLEAR, 0);
		run_op(hbm_pkg::FUNC_CLEAR, 0);
		run_op(hbm_pkg::FUNC_FIND, 12345);
		run_op(hbm_pkg::FUNC_CLEAR, 32767);
		run_op(hbm_pkg::FUNC_FIND, 0);
		run_op(hbm_pkg::FUNC_SET, 100);

		// zero limit: everything rejected, set bits stay findable
		wait_idle(4);
		write_num_bits(16'd0);
		run_op(hbm_pkg::FUNC_SET, 5);
		run_op(hbm_pkg::FUNC_TEST, 100);
		run_op(hbm_pkg::FUNC_CLEAR, 100);
		run_op(hbm_pkg::FUNC_FIND, 0);

		// one-bit limit
		wait_idle(4);
		write_num_bits(16'd1);
		run_op(hbm_pkg::FUNC_SET, 1);
		run_op(hbm_pkg::FUNC_SET, 0);
		run_op(hbm_pkg::FUNC_TEST, 0);
		run_op(hbm_pkg::FUNC_FIND, 0);

		// limit above the store size is capped
		wait_idle(4);
		write_num_bits(16'hFFFF);
		run_op(hbm_pkg::FUNC_TEST, 100);
		run_op(hbm_pkg::FUNC_CLEAR, 0);
		run_op(hbm_pkg::FUNC_FIND, 0);
		run_op(hbm_pkg::FUNC_CLEAR, 100);

		run_phase(0, 0, 16'd32768, 275);
		run_phase(77, 0, 16'($urandom_range(4096, 32767)), 275);
		run_phase(0, 77, 16'hFFFF, 275);
		run_phase(25, 25, 16'($urandom_range(1, 1200)), 275);

		wait_idle(20);
		if (shadow.mismatch_count == 0 && shadow.pending() == 0) begin
			$display("hierarchical_bitmap_set_clear_find_top_test OK");
		end else begin
			$display("hierarchical_bitmap_set_clear_find_top_test NOT OK");
		end
		$finish;
	end

endmodule
